// ===== rtl/visible_pixel_bounding_box_defines.svh =====
// ----------------------------------------------------------------------------
// Visible pixel bounding box - assertion macros
// Shared property wrappers for the checker; clk and rst come from the scope.
// ----------------------------------------------------------------------------
`ifndef VISIBLE_PIXEL_BOUNDING_BOX_DEFINES_SVH
`define VISIBLE_PIXEL_BOUNDING_BOX_DEFINES_SVH

// same-cycle implication, held off during reset
`define VPBB_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vpbb: same-cycle check failed");

// next-cycle implication, held off during reset
`define VPBB_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vpbb: next-cycle check failed");

// condition that must hold on the cycle after reset is seen
`define VPBB_ASSERT_RST(name, cons) \
  name: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("vpbb: post-reset check failed");

`endif

// ===== rtl/vpbb_pkg.sv =====
// ----------------------------------------------------------------------------
// Visible pixel bounding box - package
// Widths, register indexes, format and function codes, config and result types, helpers.
// ----------------------------------------------------------------------------
package vpbb_pkg;

  localparam int unsigned COORD_W           = 10;
  localparam int unsigned SIDE_W            = 11;
  localparam int unsigned MAX_SIDE          = 1024;
  localparam int unsigned PALETTE_DEPTH_DEF = 256;
  localparam int unsigned PIXEL_W           = 32;
  localparam int unsigned ALPHA_W           = 8;
  localparam int unsigned ABITS_W           = 4;
  localparam int unsigned SHIFT_W           = 5;
  localparam int unsigned COUNT_W           = 9;
  localparam int unsigned CFG_ADDR_W        = 3;
  localparam int unsigned CFG_DATA_W        = 32;
  localparam int unsigned QUEUE_DEPTH       = 2;
  localparam int unsigned S_TDATA_W         = 40;
  localparam int unsigned M_TDATA_W         = 48;

  localparam logic [ALPHA_W-1:0] VIS_THRESHOLD = 8'd64;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_FRAME_WIDTH     = 3'd0,
    REG_FRAME_HEIGHT    = 3'd1,
    REG_KEY_ENABLE      = 3'd2,
    REG_TRANSPARENT_KEY = 3'd3,
    REG_FORMAT_MODE     = 3'd4,
    REG_ALPHA_SHIFT     = 3'd5,
    REG_ALPHA_BITS      = 3'd6,
    REG_PALETTE_COUNT   = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    FMT_PALETTE    = 2'd0,
    FMT_ALPHA_MASK = 2'd1,
    FMT_OPAQUE     = 2'd2,
    FMT_UNKNOWN    = 2'd3
  } fmt_t;

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_PIXEL = 1'b1
  } func_t;

  typedef struct packed {
    logic [SIDE_W-1:0]  frame_width;
    logic [SIDE_W-1:0]  frame_height;
    logic               key_enable;
    logic [PIXEL_W-1:0] transparent_key;
    fmt_t               format_mode;
    logic [SHIFT_W-1:0] alpha_shift;
    logic [ABITS_W-1:0] alpha_bits;
    logic [COUNT_W-1:0] palette_count;
  } cfg_t;

  typedef struct packed {
    logic               found;
    logic [COORD_W-1:0] top_gap;
    logic [COORD_W-1:0] bottom_gap;
    logic [COORD_W-1:0] left_gap;
    logic [COORD_W-1:0] right_gap;
  } result_t;

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] r;
    r = v;
    if (v == '0) r = SIDE_W'(1);
    else if (v > SIDE_W'(MAX_SIDE)) r = SIDE_W'(MAX_SIDE);
    return r;
  endfunction

  function automatic logic [COORD_W-1:0] border_after(input logic [SIDE_W-1:0] side,
                                                      input logic [COORD_W-1:0] most);
    logic [SIDE_W-1:0] most_p1;
    logic [SIDE_W-1:0] diff;
    most_p1 = {1'b0, most} + SIDE_W'(1);
    diff    = side - most_p1;
    return (most_p1 >= side) ? '0 : diff[COORD_W-1:0];
  endfunction

endpackage

// ===== rtl/visible_pixel_bounding_box.sv =====
// ----------------------------------------------------------------------------
// Visible pixel bounding box - top level
// Finds the visible extent of a raster image and reports its four
// transparent border widths.
//
// Input stream s_*: one beat per pixel in raster order (tuser = 1), or a
// palette alpha load (tuser = 0). Loads update the alpha table and give no
// output. Output stream m_*: one beat per frame, after its last pixel.
// Configuration: cfg_we / cfg_addr / cfg_data write one register per cycle;
// change it only while no pixel is in flight.
// Throughput: one beat per cycle while s_tready is high. The palette RAM read
// sits in the front end, so a pixel passes the front stage register and the
// queue to the accumulator; the result beat is registered as the last pixel pops.
// A two-entry queue decouples classifier and accumulator; a held result
// stalls only the last pixel of the next frame, so s_tready stays high
// until the queue and the front stage fill behind it.
// Reset: registers take their defaults, frame position and extents clear.
// The palette table is not cleared; load entries before using them.
// ----------------------------------------------------------------------------
module visible_pixel_bounding_box
  import vpbb_pkg::*;
#(
  parameter int unsigned PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic                  s_tuser,   // func
  input  logic [S_TDATA_W-1:0]  s_tdata,   // pixel_value[31:0], entry_alpha[39:32]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata    // found[0], top_gap[10:1],
                                           // bottom_gap[20:11], left_gap[30:21],
                                           // right_gap[40:31], zero[47:41]
);

  cfg_t    cfg;
  logic    q_valid;
  logic    q_ready;
  logic    q_vis_in;
  logic    q_vis_out;
  logic    q_full;
  logic    q_empty;
  logic    q_pop;
  result_t result;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width     <= SIDE_W'(32);
      cfg.frame_height    <= SIDE_W'(32);
      cfg.key_enable      <= 1'b0;
      cfg.transparent_key <= '0;
      cfg.format_mode     <= FMT_ALPHA_MASK;
      cfg.alpha_shift     <= SHIFT_W'(24);
      cfg.alpha_bits      <= ABITS_W'(8);
      cfg.palette_count   <= COUNT_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_FRAME_WIDTH:     cfg.frame_width     <= cfg_data[SIDE_W-1:0];
        REG_FRAME_HEIGHT:    cfg.frame_height    <= cfg_data[SIDE_W-1:0];
        REG_KEY_ENABLE:      cfg.key_enable      <= cfg_data[0];
        REG_TRANSPARENT_KEY: cfg.transparent_key <= cfg_data[PIXEL_W-1:0];
        REG_FORMAT_MODE:     cfg.format_mode     <= fmt_t'(cfg_data[1:0]);
        REG_ALPHA_SHIFT:     cfg.alpha_shift     <= cfg_data[SHIFT_W-1:0];
        REG_ALPHA_BITS:      cfg.alpha_bits      <= cfg_data[ABITS_W-1:0];
        REG_PALETTE_COUNT:   cfg.palette_count   <= cfg_data[COUNT_W-1:0];
        default:             cfg                 <= cfg;
      endcase
    end
  end

  vpbb_front #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_vis    (q_vis_in)
  );

  assign q_ready = !q_full;

  vpbb_fifo #(
    .WIDTH (1),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_valid),
    .push_data (q_vis_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_vis_out),
    .empty     (q_empty)
  );

  vpbb_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (!q_empty),
    .q_vis    (q_vis_out),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .result   (result)
  );

  assign m_tdata = {(M_TDATA_W - 41)'(0), result.right_gap, result.left_gap,
                    result.bottom_gap, result.top_gap, result.found};

endmodule

// ===== rtl/vpbb_ram.sv =====
// ----------------------------------------------------------------------------
// Visible pixel bounding box - generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module vpbb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/vpbb_fifo.sv =====
// ----------------------------------------------------------------------------
// Visible pixel bounding box - decoupling queue
// Small synchronous FIFO between the classifier and the accumulator.
// ----------------------------------------------------------------------------
module vpbb_fifo #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned PW   = $clog2(DEPTH),
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/vpbb_front.sv =====
// ----------------------------------------------------------------------------
// Visible pixel bounding box - front end
// Accepts beats, applies palette loads, classifies pixels as visible.
// ----------------------------------------------------------------------------
module vpbb_front
  import vpbb_pkg::*;
#(
  parameter int unsigned PALETTE_DEPTH = PALETTE_DEPTH_DEF,
  localparam int unsigned AW           = $clog2(PALETTE_DEPTH)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cfg_t                 cfg,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic                 s_tuser,
  input  logic [S_TDATA_W-1:0] s_tdata,
  output logic                 q_valid,
  input  logic                 q_ready,
  output logic                 q_vis
);

  logic [PIXEL_W-1:0] px;
  logic [ALPHA_W-1:0] load_alpha;
  logic               accept;
  logic               is_pixel;
  logic               key_hit;
  logic [PIXEL_W-1:0] shifted;
  logic [ABITS_W-1:0] bits_eff;
  logic [ABITS_W-1:0] pad;
  logic [ALPHA_W-1:0] field_mask;
  logic [ALPHA_W-1:0] field;
  logic [COUNT_W-1:0] cnt_eff;
  logic               in_range;
  logic               load_ok;
  logic               pre_vis;
  logic               pal_need;
  logic [ALPHA_W-1:0] ram_q;

  logic st_valid;
  logic st_pre;
  logic st_pal;

  assign px         = s_tdata[PIXEL_W-1:0];
  assign load_alpha = s_tdata[PIXEL_W +: ALPHA_W];
  assign s_tready   = !st_valid || q_ready;
  assign accept     = s_tvalid && s_tready;
  assign is_pixel   = (func_t'(s_tuser) == FUNC_PIXEL);
  assign key_hit    = cfg.key_enable && (px == cfg.transparent_key);

  // alpha field, left aligned to eight bits
  always_comb begin
    shifted = px >> cfg.alpha_shift;
    if (cfg.alpha_bits == '0) bits_eff = ABITS_W'(1);
    else if (cfg.alpha_bits > ABITS_W'(ALPHA_W)) bits_eff = ABITS_W'(ALPHA_W);
    else bits_eff = cfg.alpha_bits;
    pad        = ABITS_W'(ALPHA_W) - bits_eff;
    field_mask = {ALPHA_W{1'b1}} >> pad;
    field      = (shifted[ALPHA_W-1:0] & field_mask) << pad;
  end

  assign cnt_eff  = (cfg.palette_count > COUNT_W'(PALETTE_DEPTH)) ?
                    COUNT_W'(PALETTE_DEPTH) : cfg.palette_count;
  assign in_range = (px[PIXEL_W-1:COUNT_W] == '0) && (px[COUNT_W-1:0] < cnt_eff);
  assign load_ok  = ({1'b0, px[ALPHA_W-1:0]} < COUNT_W'(PALETTE_DEPTH));

  always_comb begin
    pre_vis  = 1'b0;
    pal_need = 1'b0;
    unique case (cfg.format_mode)
      FMT_PALETTE:    pal_need = in_range;
      FMT_ALPHA_MASK: pre_vis  = (field >= VIS_THRESHOLD);
      FMT_OPAQUE:     pre_vis  = 1'b1;
      FMT_UNKNOWN:    pre_vis  = 1'b0;
      default:        pre_vis  = 1'b0;
    endcase
    if (key_hit) begin
      pre_vis  = 1'b0;
      pal_need = 1'b0;
    end
  end

  vpbb_ram #(
    .WIDTH (ALPHA_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (accept && !is_pixel && load_ok),
    .waddr (px[AW-1:0]),
    .wdata (load_alpha),
    .re    (accept && is_pixel && pal_need),
    .raddr (px[AW-1:0]),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (s_tready) begin
      st_valid <= accept && is_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_pre <= pre_vis;
      st_pal <= pal_need;
    end
  end

  assign q_valid = st_valid;
  assign q_vis   = st_pre || (st_pal && (ram_q >= VIS_THRESHOLD));

endmodule

// ===== rtl/vpbb_back.sv =====
// ----------------------------------------------------------------------------
// Visible pixel bounding box - back end
// Raster position, running extents and the border result register.
// ----------------------------------------------------------------------------
module vpbb_back
  import vpbb_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    q_valid,
  input  logic    q_vis,
  output logic    q_pop,
  output logic    m_tvalid,
  input  logic    m_tready,
  output result_t result
);

  logic [COORD_W-1:0] column;
  logic [COORD_W-1:0] row;
  logic [COORD_W-1:0] least_x;
  logic [COORD_W-1:0] least_y;
  logic [COORD_W-1:0] most_x;
  logic [COORD_W-1:0] most_y;
  logic               seen_any;

  logic [COORD_W-1:0] least_x_next;
  logic [COORD_W-1:0] least_y_next;
  logic [COORD_W-1:0] most_x_next;
  logic [COORD_W-1:0] most_y_next;
  logic               seen_any_next;

  logic [SIDE_W-1:0] w_eff;
  logic [SIDE_W-1:0] h_eff;
  logic              col_end;
  logic              row_end;
  logic              frame_end;
  result_t           result_next;

  assign w_eff     = clamp_side(cfg.frame_width);
  assign h_eff     = clamp_side(cfg.frame_height);
  assign col_end   = ({1'b0, column} + SIDE_W'(1)) >= w_eff;
  assign row_end   = ({1'b0, row} + SIDE_W'(1)) >= h_eff;
  assign frame_end = col_end && row_end;
  assign q_pop     = q_valid && (!frame_end || !m_tvalid || m_tready);

  always_comb begin
    least_x_next  = (q_vis && column < least_x) ? column : least_x;
    least_y_next  = (q_vis && row < least_y) ? row : least_y;
    most_x_next   = (q_vis && column > most_x) ? column : most_x;
    most_y_next   = (q_vis && row > most_y) ? row : most_y;
    seen_any_next = seen_any || q_vis;
    result_next   = '0;
    result_next.found = seen_any_next;
    if (seen_any_next) begin
      result_next.top_gap    = least_y_next;
      result_next.bottom_gap = border_after(h_eff, most_y_next);
      result_next.left_gap   = least_x_next;
      result_next.right_gap  = border_after(w_eff, most_x_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column   <= '0;
      row      <= '0;
      least_x  <= '1;
      least_y  <= '1;
      most_x   <= '0;
      most_y   <= '0;
      seen_any <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= (q_pop && frame_end) || (m_tvalid && !m_tready);
      if (q_pop) begin
        if (frame_end) begin
          column   <= '0;
          row      <= '0;
          least_x  <= '1;
          least_y  <= '1;
          most_x   <= '0;
          most_y   <= '0;
          seen_any <= 1'b0;
        end else begin
          least_x  <= least_x_next;
          least_y  <= least_y_next;
          most_x   <= most_x_next;
          most_y   <= most_y_next;
          seen_any <= seen_any_next;
          if (col_end) begin
            column <= '0;
            row    <= row + COORD_W'(1);
          end else begin
            column <= column + COORD_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && frame_end) begin
      result <= result_next;
    end
  end

endmodule

// ===== rtl/vpbb_checker.sv =====
// ----------------------------------------------------------------------------
// Visible pixel bounding box - port checker
// Result-stream checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "visible_pixel_bounding_box_defines.svh"

module vpbb_checker
  import vpbb_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata
);

  `VPBB_ASSERT_RST(a_idle_after_reset, !m_tvalid)

  `VPBB_ASSERT_NXT(a_stall_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  `VPBB_ASSERT_IMP(a_empty_frame_zero, m_tvalid && !m_tdata[0], m_tdata[40:1] == '0)

  `VPBB_ASSERT_IMP(a_rows_fit, m_tvalid, (11'(m_tdata[10:1]) + 11'(m_tdata[20:11])) <= 11'd1023)

  `VPBB_ASSERT_IMP(a_cols_fit, m_tvalid, (11'(m_tdata[30:21]) + 11'(m_tdata[40:31])) <= 11'd1023)

endmodule

bind visible_pixel_bounding_box vpbb_checker u_vpbb_checker (.*);
